@@ design/bmfx_pkg.sv @@
`default_nettype none

package bmfx_pkg;

  localparam logic [7:0] SYNC0_BYTE = 8'hA0;
  localparam logic [7:0] SYNC1_BYTE = 8'hA1;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;

  // Input word
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
  } out_word_t;

  // Slot of a byte within the sequence one input word can produce
  typedef enum logic [2:0] {
    POS_SYNC0 = 3'd0,
    POS_SYNC1 = 3'd1,
    POS_LEN_HI = 3'd2,
    POS_LEN_LO = 3'd3,
    POS_DATA  = 3'd4,
    POS_CSUM  = 3'd5,
    POS_CR    = 3'd6,
    POS_LF    = 3'd7
  } pos_t;

  // Everything the emitter needs to expand one input word
  typedef struct packed {
    logic        hdr;
    logic        trl;
    logic [15:0] len;
    logic [7:0]  data;
    logic [7:0]  csum;
  } plan_t;

endpackage

`default_nettype wire

@@ design/bmfx_frame_ctl.sv @@
`default_nettype none

module bmfx_frame_ctl import bmfx_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_word_t in_word,
  output plan_t         plan
);

  logic [15:0] remaining_r, remaining_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        idle;
  logic [15:0] len_s;
  logic [15:0] base;
  logic [7:0]  xor_base;

  always_comb begin
    idle     = (remaining_r == 16'd0);
    // zero length is raised to one
    len_s    = (in_word.payload_length == 16'd0) ? 16'd1 : in_word.payload_length;
    base     = idle ? len_s : remaining_r;
    xor_base = idle ? 8'd0 : xor_r;

    remaining_nxt = base - 16'd1;
    xor_nxt       = (remaining_nxt == 16'd0) ? 8'd0 : (xor_base ^ in_word.payload_byte);

    plan.hdr  = idle;
    plan.trl  = (remaining_nxt == 16'd0);
    plan.len  = len_s;
    plan.data = in_word.payload_byte;
    plan.csum = xor_base ^ in_word.payload_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= 16'd0;
      xor_r       <= 8'd0;
    end else if (accept) begin
      remaining_r <= remaining_nxt;
      xor_r       <= xor_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/bmfx_emitter.sv @@
`default_nettype none

module bmfx_emitter import bmfx_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  plan_load,
  input  wire plan_t plan_in,
  output logic       plan_free,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_word_t  out_data
);

  logic      plan_vld_r, plan_vld_nxt;
  plan_t     plan_r;
  pos_t      idx_r, idx_nxt;
  pos_t      end_pos;
  logic      out_vld_r, out_vld_nxt;
  out_word_t out_r, out_nxt;
  logic      out_load;
  logic      plan_take;

  always_comb begin
    end_pos   = plan_r.trl ? POS_LF : POS_DATA;
    out_load  = plan_vld_r && (!out_vld_r || out_ready);
    plan_take = out_load && (idx_r == end_pos);
    plan_free = !plan_vld_r || plan_take;

    out_nxt.last_of_run = (idx_r == end_pos);
    out_nxt.frame_end   = (idx_r == POS_LF);
    unique case (idx_r)
      POS_SYNC0:  out_nxt.out_byte = SYNC0_BYTE;
      POS_SYNC1:  out_nxt.out_byte = SYNC1_BYTE;
      POS_LEN_HI: out_nxt.out_byte = plan_r.len[15:8];
      POS_LEN_LO: out_nxt.out_byte = plan_r.len[7:0];
      POS_DATA:   out_nxt.out_byte = plan_r.data;
      POS_CSUM:   out_nxt.out_byte = plan_r.csum;
      POS_CR:     out_nxt.out_byte = CR_BYTE;
      POS_LF:     out_nxt.out_byte = LF_BYTE;
      default:    out_nxt.out_byte = 8'd0;
    endcase

    // advance slot, or restart at a freshly loaded plan
    if (plan_load) begin
      idx_nxt = plan_in.hdr ? POS_SYNC0 : POS_DATA;
    end else if (out_load) begin
      idx_nxt = pos_t'(idx_r + 3'd1);
    end else begin
      idx_nxt = idx_r;
    end

    if (plan_load) begin
      plan_vld_nxt = 1'b1;
    end else if (plan_take) begin
      plan_vld_nxt = 1'b0;
    end else begin
      plan_vld_nxt = plan_vld_r;
    end

    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      idx_r      <= POS_SYNC0;
    end else begin
      plan_vld_r <= plan_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (plan_load) begin
      plan_r <= plan_in;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    plan_load |-> plan_free)
    else $error("plan loaded while previous plan still pending");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.frame_end) |-> out_r.last_of_run)
    else $error("frame end without last_of_run");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (plan_vld_r && !plan_r.trl) |-> (idx_r == POS_SYNC0 || idx_r == POS_SYNC1 ||
      idx_r == POS_LEN_HI || idx_r == POS_LEN_LO || idx_r == POS_DATA))
    else $error("slot past data byte without trailer");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_vld_r && !plan_vld_r))
    else $error("valid state survived reset");

endmodule

`default_nettype wire

@@ design/binary_message_framer_xor.sv @@
`default_nettype none

// Channel  Direction  Handshake            Word
// in_      input      in_valid/in_ready    in_word_t  {payload_byte, payload_length}
// out_     output     out_valid/out_ready  out_word_t {out_byte, last_of_run, frame_end}
//
// Expansion: mid-frame, one input word becomes one output word; a new word is taken
//   every cycle while out_ready stays high. The first word of a frame adds the header,
//   the closing word the checksum and trailer, a one-byte frame both; the emitter's
//   single plan slot takes no new word until the last byte of its plan is loaded.
// Path: a taken word is registered as a plan, then each byte in the output register.
// Reset: rst_n synchronous, active low; clears byte countdown, checksum and valid flags.
// Stalls: out_ready low holds the output register; the plan slot then fills and
//   in_ready drops until the emitter drains.
module binary_message_framer_xor import bmfx_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  logic  in_accept;
  logic  plan_free;
  plan_t plan;

  // take a word whenever the emitter's plan slot is free or freeing this cycle
  assign in_ready  = plan_free;
  assign in_accept = in_valid && plan_free;

  // frame tracking: length countdown and running checksum
  bmfx_frame_ctl u_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_word (in_data),
    .plan    (plan)
  );

  // expand each plan into its byte, plus header and trailer words where the plan asks
  bmfx_emitter u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .plan_load (in_accept),
    .plan_in   (plan),
    .plan_free (plan_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ dv/bmfx_checker.sv @@
`default_nettype none

module bmfx_checker import bmfx_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_word_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_word_t out_data,
  output int             fail_count,
  output int             words_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  out_word_t   framed_q[$];
  logic [15:0] frame_left;
  logic [7:0]  frame_xor;

  task automatic owe_byte(input logic [7:0] b, input logic closing);
    out_word_t w;
    w.out_byte    = b;
    w.last_of_run = 1'b0;
    w.frame_end   = closing;
    framed_q.push_back(w);
  endtask

  // Expand one accepted input word into the framed bytes it must produce
  task automatic frame_word(input in_word_t w);
    logic [15:0] len;
    out_word_t   tail;
    len = w.payload_length;
    if (frame_left == 16'd0) begin
      if (len == 16'd0) len = 16'd1;
      owe_byte(SYNC0_BYTE, 1'b0);
      owe_byte(SYNC1_BYTE, 1'b0);
      owe_byte(len[15:8], 1'b0);
      owe_byte(len[7:0], 1'b0);
      frame_xor  = '0;
      frame_left = len;
    end
    owe_byte(w.payload_byte, 1'b0);
    frame_xor  = frame_xor ^ w.payload_byte;
    frame_left = frame_left - 16'd1;
    if (frame_left == 16'd0) begin
      owe_byte(frame_xor, 1'b0);
      owe_byte(CR_BYTE, 1'b0);
      owe_byte(LF_BYTE, 1'b1);
      frame_xor = '0;
    end
    tail = framed_q.pop_back();
    tail.last_of_run = 1'b1;
    framed_q.push_back(tail);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      framed_q.delete();
      frame_left = '0;
      frame_xor  = '0;
    end else begin
      // Check the output first: a word going out now never stems from this edge's input
      if (out_valid && out_ready) begin
        if (framed_q.size() == 0) begin
          $error("unexpected output word %h", out_data);
          fail_count++;
        end else begin
          want = framed_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
            fail_count++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run,
                   out_data.last_of_run);
            fail_count++;
          end
          if (out_data.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, out_data.frame_end);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) frame_word(in_data);
    end
    words_owed = framed_q.size();
  end

endmodule

`default_nettype wire

@@ dv/tb_binary_message_framer_xor.sv @@
`default_nettype none

module tb_binary_message_framer_xor;
  timeunit 1ns;
  timeprecision 1ps;
  import bmfx_pkg::*;

  localparam int HOLD_CYCLES = 80;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int fail_count;
  int words_owed;
  int items_sent = 0;

  // Idle percentages per side, changed between phases
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Receiver hold-off request and the receiver's own cycle count for it
  logic hold_on = 1'b0;
  int   hold_count = 0;

  binary_message_framer_xor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  bmfx_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .words_owed(words_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random ready, or a long hold-off while hold_on is up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_count <= 0;
    end else if (hold_on && hold_count < HOLD_CYCLES) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      if (!hold_on) hold_count <= 0;
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one word; return once it has been taken. Valid drops only on an idle
  // cycle, so back-to-back words keep valid high without a glitch.
  task automatic send_word(input logic [7:0] b, input logic [15:0] len);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{payload_byte: b, payload_length: len};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // One whole frame: length on the first word, random noise in the ignored
  // length field of every later word
  task automatic send_frame(input logic [15:0] len);
    int n;
    n = (len == 16'd0) ? 1 : int'(len);
    for (int i = 0; i < n; i++) begin
      send_word(8'($urandom_range(255)), (i == 0) ? len : 16'($urandom));
    end
  endtask

  // Mostly short frames, some zero-length, a few longer ones
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'd0;
    if (r < 65) return 16'($urandom_range(6, 1));
    if (r < 95) return 16'($urandom_range(40, 7));
    return 16'($urandom_range(120, 41));
  endfunction

  task automatic random_frames(input int upto);
    while (items_sent < upto) send_frame(pick_length());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver idles about half the time
    tx_idle_pct = 16;
    rx_idle_pct = 53;

    // One-byte frame, zero payload byte: header, byte, checksum, trailer at once
    send_word(8'h00, 16'd1);
    // Zero length gets raised to one
    send_word(8'hFF, 16'd0);
    // Two-byte frame; full-scale length on the second word must be ignored
    send_word(8'hFF, 16'd2);
    send_word(8'h00, 16'hFFFF);
    // Payload that looks like sync and trailer bytes
    send_word(SYNC0_BYTE, 16'd4);
    send_word(SYNC1_BYTE, 16'd0);
    send_word(CR_BYTE, 16'h8000);
    send_word(LF_BYTE, 16'h5555);
    // Checksum cancelling to zero; zero length mid-frame must not close it
    send_word(8'h5A, 16'd3);
    send_word(8'hA5, 16'd0);
    send_word(8'hFF, 16'hAAAA);

    random_frames(110);

    // Phase two: roles swapped
    tx_idle_pct = 53;
    rx_idle_pct = 16;

    // Hold off the receiver while the sender keeps offering back-to-back words,
    // so the block fills and pulls in_ready low
    tx_idle_pct = 0;
    hold_on <= 1'b1;
    send_frame(16'd30);
    hold_on <= 1'b0;
    tx_idle_pct = 53;

    random_frames(220);

    // Phase three: no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_frames(326);

    // Long length with distinct header bytes; the frame stays open at the end
    send_word(8'($urandom_range(255)), 16'hFF01);
    repeat (3) send_word(8'($urandom_range(255)), 16'($urandom));

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("[binary_message_framer_xor] OK");
    end else begin
      $display("[binary_message_framer_xor] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #10ms;
    $display("[binary_message_framer_xor] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
